/* src/assert_macros.svh */
// Assertion macros used by the RTL of the sample range normalizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// General clocked property, switched off while reset is asserted.
`define SRN_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// A control signal is low in the cycle after reset.
`define SRN_ASSERT_RESET(lbl, clk, rst_n, sig, msg) \
    lbl: assert property (@(posedge clk) !rst_n |=> !sig) else $error(msg);
`else
`define SRN_ASSERT(lbl, clk, rst_n, prop, msg)
`define SRN_ASSERT_RESET(lbl, clk, rst_n, sig, msg)
`endif
`endif

/* src/srn_pkg.sv */
`default_nettype none
package srn_pkg;

    localparam int LANES   = 8;
    localparam int WORD_W  = 16;
    localparam int SCALE_W = 25;
    localparam int MHI_W   = SCALE_W - WORD_W;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    typedef logic [WORD_W-1:0] t_word;

    localparam t_word WORD_MAX = 16'hFFFF;

    // Register indexes, addressed at 4 * index.
    localparam logic [2:0] REG_NORM_EN = 3'd0;
    localparam logic [2:0] REG_FILL    = 3'd1;
    localparam logic [2:0] REG_SCALE   = 3'd2;
    localparam logic [2:0] REG_CLAMP   = 3'd3;
    localparam logic [2:0] REG_BIAS    = 3'd4;
    localparam logic [2:0] REG_ROUND   = 3'd5;

    typedef enum logic [1:0] {
        MODE_FILL,
        MODE_COPY,
        MODE_MASK,
        MODE_NORM
    } t_mode;

    typedef struct packed {
        t_word sample_0;
        t_word sample_1;
        t_word sample_2;
        t_word sample_3;
        t_word sample_4;
        t_word sample_5;
        t_word sample_6;
        t_word sample_7;
        logic  span_end;
    } t_in_word;

    typedef struct packed {
        t_word result_0;
        t_word result_1;
        t_word result_2;
        t_word result_3;
        t_word result_4;
        t_word result_5;
        t_word result_6;
        t_word result_7;
        logic  result_end;
    } t_out_word;

    // Settings derived from the registers, shared by all lanes.
    typedef struct packed {
        t_mode            mode;
        t_word            fill;
        t_word            lim;
        t_word            half;
        t_word            rmask;
        t_word            p;
        t_word            q;
        logic             mask_en;
        t_word            mlo;
        logic [MHI_W-1:0] mhi;
    } t_srn_ctl;

    // Valid bits of the two pipeline stages.
    typedef struct packed {
        logic v1;
        logic v2;
    } t_srn_pipe;

endpackage
`default_nettype wire

/* src/srn_cfg.sv */
`default_nettype none
module srn_cfg
    import srn_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output t_srn_ctl               o_ctl
);

    logic               r_norm_en;
    t_word              r_fill;
    logic [SCALE_W-1:0] r_scale;
    t_word              r_clamp;
    t_word              r_bias;
    t_word              r_round;

    logic               wr_en;
    logic [2:0]         reg_idx;
    logic signed [17:0] br;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_norm_en <= 1'b0;
            r_fill    <= '0;
            r_scale   <= SCALE_W'(1);
            r_clamp   <= '0;
            r_bias    <= '0;
            r_round   <= 16'd1;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_NORM_EN: r_norm_en <= pwdata[0];
                REG_FILL:    r_fill    <= pwdata[WORD_W-1:0];
                REG_SCALE:   r_scale   <= pwdata[SCALE_W-1:0];
                REG_CLAMP:   r_clamp   <= pwdata[WORD_W-1:0];
                REG_BIAS:    r_bias    <= pwdata[WORD_W-1:0];
                REG_ROUND:   r_round   <= pwdata[WORD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_NORM_EN: prdata = {{(DATA_W-1){1'b0}}, r_norm_en};
            REG_FILL:    prdata = {{(DATA_W-WORD_W){1'b0}}, r_fill};
            REG_SCALE:   prdata = {{(DATA_W-SCALE_W){1'b0}}, r_scale};
            REG_CLAMP:   prdata = {{(DATA_W-WORD_W){1'b0}}, r_clamp};
            REG_BIAS:    prdata = {{(DATA_W-WORD_W){1'b0}}, r_bias};
            REG_ROUND:   prdata = {{(DATA_W-WORD_W){1'b0}}, r_round};
            default:     prdata = '0;
        endcase
    end

    // The bias plus half the round step splits into an amount to add and
    // an amount to subtract; one of them is always zero.
    assign br = {{2{r_bias[WORD_W-1]}}, r_bias} + {2'b00, (r_round >> 1)};

    always_comb begin
        o_ctl.fill    = r_fill;
        o_ctl.lim     = WORD_MAX - r_clamp;
        o_ctl.half    = r_round >> 1;
        o_ctl.rmask   = t_word'(17'h10000 - {1'b0, r_round});
        o_ctl.p       = (br > 18'sd0) ? br[WORD_W-1:0] : '0;
        o_ctl.q       = (br < 18'sd0) ? t_word'(-br) : '0;
        o_ctl.mask_en = (r_round > 16'd1);
        o_ctl.mlo     = r_scale[WORD_W-1:0];
        o_ctl.mhi     = r_scale[SCALE_W-1:WORD_W];
        if (r_fill != '0) begin
            o_ctl.mode = MODE_FILL;
        end else if (!r_norm_en && r_round == 16'd1) begin
            o_ctl.mode = MODE_COPY;
        end else if (!r_norm_en) begin
            o_ctl.mode = MODE_MASK;
        end else begin
            o_ctl.mode = MODE_NORM;
        end
    end

endmodule
`default_nettype wire

/* src/srn_lane.sv */
`default_nettype none
module srn_lane
    import srn_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_en,
    input  wire t_word    i_sample,
    input  wire t_srn_ctl i_ctl,
    output t_word         o_result
);

    function automatic t_word sat_add(input t_word a, input t_word b);
        logic [WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WORD_W] ? WORD_MAX : s[WORD_W-1:0];
    endfunction

    // Stage one: clamp, the two products and the mask path.
    t_word                    clamped;
    logic [2*WORD_W-1:0]      prod_lo;
    logic [WORD_W+MHI_W-1:0]  prod_hi;
    t_word                    rounded;
    t_word                    mask_val;

    t_word r_x;
    t_word r_hi;
    logic  r_rb;
    t_word r_b;
    t_word r_mask_val;

    always_comb begin
        clamped  = (i_sample > i_ctl.lim) ? i_ctl.lim : i_sample;
        prod_lo  = {{WORD_W{1'b0}}, clamped} * {{WORD_W{1'b0}}, i_ctl.mlo};
        prod_hi  = {{MHI_W{1'b0}}, clamped} * {{WORD_W{1'b0}}, i_ctl.mhi};
        rounded  = sat_add(i_sample, i_ctl.half);
        mask_val = ((rounded > i_ctl.lim) ? i_ctl.lim : rounded) & i_ctl.rmask;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x        <= i_sample;
            r_hi       <= prod_lo[2*WORD_W-1:WORD_W];
            r_rb       <= prod_lo[WORD_W-1];
            r_b        <= prod_hi[WORD_W-1:0];
            r_mask_val <= mask_val;
        end
    end

    // Stage two: saturating sums of the normalize path and mode select.
    // The rounding bit is dropped when the round step is above one.
    t_word v1, v2, v3, v4, norm_val;
    t_word r_result;

    always_comb begin
        v1       = sat_add(r_hi, {{(WORD_W-1){1'b0}}, r_rb && !i_ctl.mask_en});
        v2       = sat_add(v1, r_b);
        v3       = sat_add(v2, i_ctl.p);
        v4       = (v3 > i_ctl.q) ? v3 - i_ctl.q : '0;
        norm_val = i_ctl.mask_en ? (v4 & i_ctl.rmask) : v4;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (i_ctl.mode)
                MODE_FILL: r_result <= i_ctl.fill;
                MODE_COPY: r_result <= r_x;
                MODE_MASK: r_result <= r_mask_val;
                default:   r_result <= norm_val;
            endcase
        end
    end

    assign o_result = r_result;

endmodule
`default_nettype wire

/* src/srn_merge.sv */
`default_nettype none
module srn_merge
    import srn_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    input  wire logic  i_span_end,
    input  wire logic  i_out_stall,
    input  wire t_word i_results [LANES],
    output logic       o_en,
    output logic       o_in_stall,
    output t_srn_pipe  o_pipe,
    output logic       o_out_valid,
    output t_out_word  o_out_data
);

    logic r_v1;
    logic r_v2;
    logic r_end1;
    logic r_end2;

    // The whole pipe moves unless a finished word waits at a stalled output.
    assign o_en       = !r_v2 || !i_out_stall;
    assign o_in_stall = !o_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (o_en) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_end1 <= i_span_end;
            r_end2 <= r_end1;
        end
    end

    assign o_pipe.v1  = r_v1;
    assign o_pipe.v2  = r_v2;
    assign o_out_valid = r_v2;

    always_comb begin
        o_out_data.result_0   = i_results[0];
        o_out_data.result_1   = i_results[1];
        o_out_data.result_2   = i_results[2];
        o_out_data.result_3   = i_results[3];
        o_out_data.result_4   = i_results[4];
        o_out_data.result_5   = i_results[5];
        o_out_data.result_6   = i_results[6];
        o_out_data.result_7   = i_results[7];
        o_out_data.result_end = r_end2;
    end

endmodule
`default_nettype wire

/* src/sample_range_normalizer_16bit.sv */
// Channel   Valid        Stall         Word
// input     i_in_valid   o_in_stall    i_in_data  (eight samples, span end)
// output    o_out_valid  i_out_stall   o_out_data (eight results, span end)
// config    APB: psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// One word is accepted per cycle while the input is not stalled; each word is
// registered in the multiply stage and then in the saturating sum stage that
// every lane runs through, and its result leaves from the second.
// Reset is synchronous, loads the config reset values and clears the valid bits.
// A stalled output holding a result holds the whole pipe and stalls the input.
`default_nettype none
`include "assert_macros.svh"
module sample_range_normalizer_16bit
    import srn_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire t_in_word          i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output t_out_word              o_out_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    t_srn_ctl  ctl;
    t_srn_pipe pipe;
    logic      en;
    t_word     samples [LANES];
    t_word     results [LANES];

    srn_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_ctl   (ctl)
    );

    assign samples[0] = i_in_data.sample_0;
    assign samples[1] = i_in_data.sample_1;
    assign samples[2] = i_in_data.sample_2;
    assign samples[3] = i_in_data.sample_3;
    assign samples[4] = i_in_data.sample_4;
    assign samples[5] = i_in_data.sample_5;
    assign samples[6] = i_in_data.sample_6;
    assign samples[7] = i_in_data.sample_7;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        srn_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_sample (samples[g]),
            .i_ctl    (ctl),
            .o_result (results[g])
        );
    end

    srn_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_span_end  (i_in_data.span_end),
        .i_out_stall (i_out_stall),
        .i_results   (results),
        .o_en        (en),
        .o_in_stall  (o_in_stall),
        .o_pipe      (pipe),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    `SRN_ASSERT_RESET(a_reset_empty, i_clk, i_rst_n, o_out_valid, "output valid after reset")
    `SRN_ASSERT(a_stage_hold, i_clk, i_rst_n, (pipe.v1 && o_out_valid && i_out_stall) |=> pipe.v1, "word lost in first stage while output stalled")
    `SRN_ASSERT(a_stage_move, i_clk, i_rst_n, (pipe.v1 && !o_in_stall) |=> o_out_valid, "word in first stage did not reach the output")

endmodule
`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import srn_pkg::*;

    localparam int ITEMS_PER_PHASE = 50;
    localparam int RANDOM_PHASES   = 40;
    localparam int QUIET_PHASES    = 6;
    localparam int HOLD_CYCLES     = 300;
    localparam int CYCLE_LIMIT     = 400000;

    // Scoreboard: a private copy of the register file, the lane arithmetic,
    // and the queue of result words still owed by the block.
    class norm_scoreboard;
        logic               norm_on;
        t_word              fill_level;
        logic [SCALE_W-1:0] gain;
        t_word              clamp_cut;
        logic signed [15:0] offset;
        t_word              step;
        t_out_word          owed_q[$];
        int                 errors;

        function new();
            norm_on    = 1'b0;
            fill_level = '0;
            gain       = SCALE_W'(1);
            clamp_cut  = '0;
            offset     = '0;
            step       = 16'd1;
            errors     = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [DATA_W-1:0] val);
            case (idx)
                REG_NORM_EN: norm_on = val[0];
                REG_FILL:    fill_level = val[WORD_W-1:0];
                REG_SCALE:   gain = val[SCALE_W-1:0];
                REG_CLAMP:   clamp_cut = val[WORD_W-1:0];
                REG_BIAS:    offset = val[WORD_W-1:0];
                REG_ROUND:   step = val[WORD_W-1:0];
                default: ;
            endcase
        endfunction

        function t_word sat_add(t_word a, t_word b);
            logic [WORD_W:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[WORD_W] ? WORD_MAX : s[WORD_W-1:0];
        endfunction

        function t_word sat_sub(t_word a, t_word b);
            return (a > b) ? a - b : '0;
        endfunction

        function t_word scale_lane(t_word x);
            t_word            half, rmask, lim, c, mlo, hi, b, v, p, q;
            logic [MHI_W-1:0] mhi;
            logic [31:0]      prod;
            logic [24:0]      prod_hi;
            logic             rb;
            int               br;
            half  = step >> 1;
            rmask = 16'h0000 - step;
            lim   = WORD_MAX - clamp_cut;
            if (fill_level != 0)
                return fill_level;
            if (!norm_on && step == 1)
                return x;
            if (!norm_on) begin
                v = sat_add(x, half);
                if (v > lim)
                    v = lim;
                return v & rmask;
            end
            c       = (x > lim) ? lim : x;
            mlo     = gain[WORD_W-1:0];
            mhi     = gain[SCALE_W-1:WORD_W];
            prod    = {16'd0, c} * {16'd0, mlo};
            hi      = prod[31:16];
            rb      = prod[15];
            prod_hi = {9'd0, c} * {16'd0, mhi};
            b       = prod_hi[WORD_W-1:0];
            if (offset != 0 || step > 1) begin
                br = int'(offset) + int'(half);
                p  = (br > 0) ? t_word'(br) : '0;
                q  = (br < 0) ? t_word'(-br) : '0;
                if (step > 1) begin
                    // A coarse step replaces the product rounding bit.
                    v = sat_add(hi, b);
                    v = sat_sub(sat_add(v, p), q);
                    return v & rmask;
                end
                v = sat_add(sat_add(hi, {15'd0, rb}), b);
                return sat_sub(sat_add(v, p), q);
            end
            return sat_add(sat_add(hi, {15'd0, rb}), b);
        endfunction

        function void note_input(t_in_word w);
            t_out_word res;
            res = '0;
            for (int i = 0; i < LANES; i++)
                res[1+WORD_W*(LANES-1-i) +: WORD_W] =
                    scale_lane(w[1+WORD_W*(LANES-1-i) +: WORD_W]);
            res.result_end = w.span_end;
            owed_q.push_back(res);
        endfunction

        function void check_result(t_out_word got);
            t_out_word want;
            t_word     w_lane, g_lane;
            if (owed_q.size() == 0) begin
                $display("%0t: unexpected word: expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            for (int i = 0; i < LANES; i++) begin
                w_lane = want[1+WORD_W*(LANES-1-i) +: WORD_W];
                g_lane = got[1+WORD_W*(LANES-1-i) +: WORD_W];
                if (w_lane !== g_lane) begin
                    $display("%0t: result_%0d: expected %h, actual %h",
                             $time, i, w_lane, g_lane);
                    errors++;
                end
            end
            if (want.result_end !== got.result_end) begin
                $display("%0t: result_end: expected %b, actual %b",
                         $time, want.result_end, got.result_end);
                errors++;
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    t_in_word          i_in_data;
    logic              o_out_valid;
    logic              i_out_stall;
    t_out_word         o_out_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    norm_scoreboard sb;
    bit             idle_on;
    bit             hold_req;

    sample_range_normalizer_16bit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    task automatic write_reg(logic [2:0] idx, logic [DATA_W-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(bit ne, t_word fl, logic [SCALE_W-1:0] g,
                              t_word cl, t_word bi, t_word st);
        write_reg(REG_NORM_EN, {31'd0, ne});
        write_reg(REG_FILL, {16'd0, fl});
        write_reg(REG_SCALE, {7'd0, g});
        write_reg(REG_CLAMP, {16'd0, cl});
        write_reg(REG_BIAS, {16'd0, bi});
        write_reg(REG_ROUND, {16'd0, st});
    endtask

    task automatic random_config();
        bit                 ne;
        t_word              fl, cl, bi, st;
        logic [SCALE_W-1:0] g;
        ne = 1'($urandom_range(0, 1));
        fl = ($urandom_range(0, 7) == 0) ? t_word'($urandom_range(1, 65535)) : '0;
        case ($urandom_range(0, 5))
            0: g = '0;
            1: g = SCALE_W'(1);
            2: g = 25'h0010000;
            3: g = 25'h1FFFFFF;
            4: g = SCALE_W'($urandom_range(0, 25'h001FFFF));
            default: g = SCALE_W'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0: cl = '0;
            1: cl = 16'hFFFF;
            default: cl = t_word'($urandom_range(0, 65535));
        endcase
        case ($urandom_range(0, 4))
            0, 1: bi = '0;
            2: bi = t_word'($urandom_range(0, 65535));
            3: bi = 16'h8000;
            default: bi = 16'h7FFF;
        endcase
        case ($urandom_range(0, 9))
            7: st = '0;
            8: st = t_word'($urandom_range(0, 65535));
            9: st = 16'd1;
            default: st = t_word'(1) << $urandom_range(0, 15);
        endcase
        set_config(ne, fl, g, cl, bi, st);
    endtask

    // Offer one word and return at the edge that accepts it.
    task automatic send_word(t_in_word w);
        int n;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 18);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(w);
    endtask

    // Drop valid and wait until every owed word has come back.
    task automatic close_phase();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_word pick_sample();
        t_word lim;
        lim = WORD_MAX - sb.clamp_cut;
        case ($urandom_range(0, 7))
            0: return '0;
            1: return WORD_MAX;
            2: return lim + t_word'($urandom_range(0, 4)) - 16'd2;
            default: return t_word'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic t_in_word random_word();
        t_in_word w;
        w = '0;
        for (int i = 0; i < LANES; i++)
            w[1+WORD_W*(LANES-1-i) +: WORD_W] = pick_sample();
        w.span_end = 1'($urandom_range(0, 1));
        return w;
    endfunction

    task automatic run_directed();
        t_in_word w;
        t_word    lim;
        lim = WORD_MAX - sb.clamp_cut;
        w = '0;
        send_word(w);
        w = '1;
        send_word(w);
        w.sample_0 = 16'h0001;
        w.sample_1 = 16'h7FFF;
        w.sample_2 = 16'h8000;
        w.sample_3 = 16'hFFFE;
        w.sample_4 = lim;
        w.sample_5 = lim + 16'd1;
        w.sample_6 = lim - 16'd1;
        w.sample_7 = t_word'($urandom_range(0, 65535));
        w.span_end = 1'b1;
        send_word(w);
        close_phase();
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_out_data);
    end

    // Receiver: random stall bursts, plus one long hold when asked for.
    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 18);
                i_out_stall <= 1'b1;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("** sample_range_normalizer_16bit: FAILED **");
        $finish;
    end

    initial begin
        sb          = new();
        idle_on     = 1'b1;
        hold_req    = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_stall = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values give the plain copy path.
        run_directed();
        set_config(1'b0, 16'hFFFF, 25'd1, 16'h0000, 16'h0000, 16'd1);
        run_directed();
        set_config(1'b0, 16'h0000, 25'd1, 16'h0100, 16'h0000, 16'd16);
        run_directed();
        set_config(1'b1, 16'h0000, 25'h1FFFFFF, 16'h0000, 16'h0000, 16'd1);
        run_directed();
        set_config(1'b1, 16'h0000, 25'h0018000, 16'h0FFF, 16'h8000, 16'd1);
        run_directed();
        set_config(1'b1, 16'h0000, 25'h000C000, 16'hFFFF, 16'h7FFF, 16'h8000);
        run_directed();
        // A zero step: no step rounding or masking when normalizing, zero when masking.
        set_config(1'b1, 16'h0000, 25'h0010000, 16'h0000, 16'h0005, 16'd0);
        run_directed();
        set_config(1'b0, 16'h0000, 25'h0010000, 16'h0000, 16'h0000, 16'd0);
        run_directed();
        set_config(1'b0, 16'h0000, 25'd1, 16'h0000, 16'h0000, 16'd3);
        run_directed();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            idle_on = (ph < RANDOM_PHASES - QUIET_PHASES) && (ph % 7 != 3);
            random_config();
            if (ph == 10 || ph == 25)
                hold_req = 1'b1;
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
                send_word(random_word());
            close_phase();
        end

        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("** sample_range_normalizer_16bit: PASSED **");
        end else begin
            $display("** sample_range_normalizer_16bit: FAILED **");
        end
        $finish;
    end

endmodule
